[hw/rtl/tcpopt_pkg.sv]
`default_nettype none

package tcpopt_pkg;

	// One word of the input channel: a byte of the option area.
	typedef struct packed {
		logic [7:0] option_byte;
		logic       last_byte;
	} tcpopt_in_t;

	// One word of the output channel: status and gathered option fields.
	typedef struct packed {
		logic        status;
		logic [15:0] max_segment_size;
		logic        sack_allowed;
		logic [31:0] stamp_value;
		logic [31:0] stamp_echo;
		logic [7:0]  window_shift;
	} tcpopt_out_t;

	// Option kind bytes as they appear on the wire.
	localparam logic [7:0] OPT_EOL   = 8'd0;
	localparam logic [7:0] OPT_NOP   = 8'd1;
	localparam logic [7:0] OPT_MSS   = 8'd2;
	localparam logic [7:0] OPT_WS    = 8'd3;
	localparam logic [7:0] OPT_SACK  = 8'd4;
	localparam logic [7:0] OPT_TS    = 8'd8;

	// Internal code of the option under way.
	localparam logic [2:0] KIND_IDLE = 3'd0;
	localparam logic [2:0] KIND_MSS  = 3'd1;
	localparam logic [2:0] KIND_SACK = 3'd2;
	localparam logic [2:0] KIND_TS   = 3'd3;
	localparam logic [2:0] KIND_WS   = 3'd4;

	// Fixed option lengths in bytes, kind and length bytes included.
	localparam logic [3:0] LEN_MSS   = 4'd4;
	localparam logic [3:0] LEN_SACK  = 4'd2;
	localparam logic [3:0] LEN_TS    = 4'd10;
	localparam logic [3:0] LEN_WS    = 4'd3;

	// Length that a given internal kind must carry.
	function automatic logic [3:0] opt_len(input logic [2:0] kind);
		logic [3:0] len;
		begin
			unique case (kind)
				KIND_MSS:  len = LEN_MSS;
				KIND_SACK: len = LEN_SACK;
				KIND_TS:   len = LEN_TS;
				KIND_WS:   len = LEN_WS;
				default:   len = 4'd0;
			endcase
			return len;
		end
	endfunction

endpackage

`default_nettype wire

[hw/rtl/tcp_option_parser.sv]
// TCP option area parser.
// The input channel (in_valid, in_ready, in_data) carries the option area one
// byte per word in wire order, with last_byte set on the final byte of an area.
// The output channel (out_valid, out_ready, out_data) carries one word per area:
// the status bit and the MSS, SACK-permitted, timestamp and window scale fields.
// A byte is taken into an input register, and from there the parser state is
// updated from it; the final byte of an area instead clears the parser state
// and loads the result register, which shows the result. Throughput is one
// byte per cycle, sustained across area boundaries while the receiver takes
// results; the rate is set by the parser state update from the input register.
// When the receiver stalls, the result waits in the output register; bytes that
// are not final keep flowing, and the next final byte waits in the input
// register, holding in_ready low, until the held result is taken.
// Reset clears the parser state, the gathered fields and both valid flags, so
// the first byte after reset is read as the kind byte of a fresh area.
`default_nettype none

module tcp_option_parser
	import tcpopt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire tcpopt_in_t  in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output tcpopt_out_t      out_data
);

	// Input register.
	logic       valid_s1;
	tcpopt_in_t data_s1;
	logic       adv_s1;

	// Parser state.
	logic [3:0]  bio_q;
	logic [2:0]  kind_q;
	logic        stopped_q;
	logic        bad_q;
	logic [15:0] mss_q;
	logic        sack_q;
	logic [31:0] tsval_q;
	logic [31:0] tsecr_q;
	logic [7:0]  wscale_q;
	logic [63:0] pend_q;

	// Next-state values.
	logic [3:0]  bio_d;
	logic [2:0]  kind_d;
	logic        stopped_d;
	logic        bad_d;
	logic [15:0] mss_d;
	logic        sack_d;
	logic [31:0] tsval_d;
	logic [31:0] tsecr_d;
	logic [7:0]  wscale_d;
	logic [63:0] pend_d;
	logic        commit;
	logic [3:0]  bio_inc;
	tcpopt_out_t result;

	// A final byte may leave the input register only when the result slot frees.
	assign adv_s1   = valid_s1 && (!data_s1.last_byte || !out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Update of the parser state by one byte.
	always_comb begin
		bio_d     = bio_q;
		kind_d    = kind_q;
		stopped_d = stopped_q;
		bad_d     = bad_q;
		mss_d     = mss_q;
		sack_d    = sack_q;
		tsval_d   = tsval_q;
		tsecr_d   = tsecr_q;
		wscale_d  = wscale_q;
		pend_d    = pend_q;
		commit    = 1'b0;
		bio_inc   = bio_q + 4'd1;

		if (!stopped_q && !bad_q) begin
			if (kind_q == KIND_IDLE) begin
				// Kind byte: open an option, or handle the one-byte kinds.
				unique case (data_s1.option_byte)
					OPT_EOL:  stopped_d = 1'b1;
					OPT_NOP:  ;
					OPT_MSS:  kind_d = KIND_MSS;
					OPT_WS:   kind_d = KIND_WS;
					OPT_SACK: kind_d = KIND_SACK;
					OPT_TS:   kind_d = KIND_TS;
					default:  bad_d = 1'b1;
				endcase
				if (kind_d != KIND_IDLE) begin
					bio_d  = 4'd1;
					pend_d = 64'd0;
				end
			end else if (bio_q == 4'd1) begin
				// Length byte must match the fixed length of the kind.
				if (data_s1.option_byte != {4'd0, opt_len(kind_q)}) begin
					bad_d = 1'b1;
				end else begin
					bio_d  = 4'd2;
					commit = (4'd2 >= opt_len(kind_q));
				end
			end else begin
				// Value byte: shift it into the pending value.
				pend_d = {pend_q[55:0], data_s1.option_byte};
				bio_d  = bio_inc;
				commit = (bio_inc >= opt_len(kind_q));
			end
		end

		// A complete option moves its value into the gathered fields.
		if (commit) begin
			unique case (kind_q)
				KIND_MSS:  mss_d = pend_d[15:0];
				KIND_SACK: sack_d = 1'b1;
				KIND_TS: begin
					tsval_d = pend_d[63:32];
					tsecr_d = pend_d[31:0];
				end
				KIND_WS:   wscale_d = pend_d[7:0];
				default:   ;
			endcase
			kind_d = KIND_IDLE;
			bio_d  = 4'd0;
			pend_d = 64'd0;
		end

		// An option still open at the end of the area is a truncation.
		if (data_s1.last_byte && !stopped_d && !bad_d && kind_d != KIND_IDLE) begin
			bad_d = 1'b1;
		end

		result.status           = bad_d;
		result.max_segment_size = mss_d;
		result.sack_allowed     = sack_d;
		result.stamp_value      = tsval_d;
		result.stamp_echo       = tsecr_d;
		result.window_shift     = wscale_d;
	end

	// Parser state registers; the final byte clears everything for the next area.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bio_q     <= 4'd0;
			kind_q    <= KIND_IDLE;
			stopped_q <= 1'b0;
			bad_q     <= 1'b0;
			mss_q     <= 16'd0;
			sack_q    <= 1'b0;
			tsval_q   <= 32'd0;
			tsecr_q   <= 32'd0;
			wscale_q  <= 8'd0;
			pend_q    <= 64'd0;
		end else if (adv_s1) begin
			if (data_s1.last_byte) begin
				bio_q     <= 4'd0;
				kind_q    <= KIND_IDLE;
				stopped_q <= 1'b0;
				bad_q     <= 1'b0;
				mss_q     <= 16'd0;
				sack_q    <= 1'b0;
				tsval_q   <= 32'd0;
				tsecr_q   <= 32'd0;
				wscale_q  <= 8'd0;
				pend_q    <= 64'd0;
			end else begin
				bio_q     <= bio_d;
				kind_q    <= kind_d;
				stopped_q <= stopped_d;
				bad_q     <= bad_d;
				mss_q     <= mss_d;
				sack_q    <= sack_d;
				tsval_q   <= tsval_d;
				tsecr_q   <= tsecr_d;
				wscale_q  <= wscale_d;
				pend_q    <= pend_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && data_s1.last_byte) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && data_s1.last_byte) begin
			out_data <= result;
		end
	end

endmodule

`default_nettype wire
